@@ hdl/asacu_pkg.sv @@
// Shared types, widths, coefficients and an arithmetic helper of the arcsine/arccosine unit.
package asacu_pkg;

    localparam int XW = 32;
    localparam int GW = 31;
    localparam int AW = 36;
    localparam int YW = 34;
    localparam int RW = 37;
    localparam int QW = 32;
    localparam int NW = AW + 32;
    localparam int HS = 5;

    localparam logic [XW-1:0] ONE_Q30    = 32'h4000_0000;
    localparam logic [XW-1:0] HALF_Q30   = 32'h2000_0000;
    localparam logic [XW-1:0] TINY_LIMIT = 32'd12;

    localparam logic signed [RW-1:0] PIO2_Q32 = 37'sd6746518853;
    localparam logic signed [RW-1:0] PI_Q32   = 37'sd13493037705;
    localparam logic signed [XW-1:0] PIO2_Q29 = 32'sd843314857;
    localparam logic signed [XW-1:0] PI_Q29   = 32'sd1686629713;

    localparam logic signed [AW-1:0] P_COEF [5] = '{
        -36'sd459167144, 36'sd959794796, -36'sd665868627, 36'sd170331058, -36'sd11689454
    };
    localparam logic signed [AW-1:0] Q_COEF [6] = '{
        -36'sd2755002865, 36'sd6998520066, -36'sd6406598597, 36'sd2532566195,
        -36'sd399698031, 36'sd16777216
    };

    typedef struct packed {
        logic                   kind;
        logic                   neg;
        logic                   big;
        logic                   rat;
        logic                   special;
        logic                   err;
        logic                   rneg;
        logic                   qzero;
        logic [XW-1:0]          spec_angle;
        logic [GW-1:0]          g;
        logic signed [YW-1:0]   y;
    } side_t;

    // Product a*g scaled down by 2^32, rounded to nearest with ties away from zero.
    function automatic logic signed [AW-1:0] mul_q32_round(
        input logic signed [AW-1:0] a,
        input logic [GW-1:0]        g
    );
        logic [AW-1:0]      mag;
        logic [AW+GW-1:0]   p;
        logic [AW+GW-1:0]   pr;
        logic [AW-2:0]      rnd;
        mag = a[AW-1] ? AW'(-a) : AW'(a);
        p   = (AW+GW)'(mag) * (AW+GW)'(g);
        pr  = p + ((AW+GW)'(1) << 31);
        rnd = pr[AW+GW-1:32];
        return a[AW-1] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
    endfunction

endpackage

@@ hdl/asacu_sqrt.sv @@
// Pipelined integer square root, one result bit per register stage.
module asacu_sqrt (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  asacu_pkg::side_t           in_side,
    input  logic [asacu_pkg::GW-1:0]   in_rad,
    output logic                       out_valid,
    output asacu_pkg::side_t           out_side,
    output logic [asacu_pkg::GW-1:0]   out_root
);

    localparam int NS = asacu_pkg::GW;
    localparam int VW = asacu_pkg::GW + 32;

    logic                     vld_reg  [NS];
    asacu_pkg::side_t         side_reg [NS];
    logic [VW-1:0]            rem_reg  [NS];
    logic [asacu_pkg::GW-1:0] root_reg [NS];

    for (genvar i = 0; i < NS; i++) begin : g_stg
        localparam int K = NS - 1 - i;
        logic                     vld_in;
        asacu_pkg::side_t         side_in;
        logic [VW-1:0]            rem_in;
        logic [VW-1:0]            rem_next;
        logic [VW-1:0]            trial;
        logic [asacu_pkg::GW-1:0] root_in;
        logic [asacu_pkg::GW-1:0] root_next;

        if (i == 0) begin : g_first
            assign vld_in  = in_valid;
            assign side_in = in_side;
            assign rem_in  = {in_rad, 32'b0};
            assign root_in = '0;
        end else begin : g_rest
            assign vld_in  = vld_reg[i-1];
            assign side_in = side_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
        end

        always_comb begin
            trial = (VW'(root_in) << (K + 1)) | (VW'(1) << (2 * K));
            if (rem_in >= trial) begin
                rem_next  = rem_in - trial;
                root_next = root_in | (asacu_pkg::GW'(1) << K);
            end else begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[i] <= side_in;
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_side  = side_reg[NS-1];
    assign out_root  = root_reg[NS-1];

endmodule

@@ hdl/asacu_horner.sv @@
// Pipelined evaluation of the numerator and denominator polynomials, one step per stage.
module asacu_horner (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  asacu_pkg::side_t                  in_side,
    output logic                              out_valid,
    output asacu_pkg::side_t                  out_side,
    output logic signed [asacu_pkg::AW-1:0]   out_p,
    output logic signed [asacu_pkg::AW-1:0]   out_q
);

    localparam int NS = asacu_pkg::HS;

    logic                            vld_reg  [NS];
    asacu_pkg::side_t                side_reg [NS];
    logic signed [asacu_pkg::AW-1:0] p_reg    [NS];
    logic signed [asacu_pkg::AW-1:0] q_reg    [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stg
        logic                            vld_in;
        asacu_pkg::side_t                side_in;
        logic signed [asacu_pkg::AW-1:0] p_in;
        logic signed [asacu_pkg::AW-1:0] q_in;
        logic signed [asacu_pkg::AW-1:0] p_add;
        logic signed [asacu_pkg::AW-1:0] p_next;
        logic signed [asacu_pkg::AW-1:0] q_next;

        if (s == 0) begin : g_first
            assign vld_in  = in_valid;
            assign side_in = in_side;
            assign p_in    = asacu_pkg::P_COEF[4];
            assign q_in    = asacu_pkg::Q_COEF[5];
        end else begin : g_rest
            assign vld_in  = vld_reg[s-1];
            assign side_in = side_reg[s-1];
            assign p_in    = p_reg[s-1];
            assign q_in    = q_reg[s-1];
        end

        if (s < NS - 1) begin : g_padd
            assign p_add = asacu_pkg::P_COEF[NS-2-s];
        end else begin : g_plast
            assign p_add = '0;
        end

        always_comb begin
            p_next = asacu_pkg::mul_q32_round(p_in, side_in.g) + p_add;
            q_next = asacu_pkg::mul_q32_round(q_in, side_in.g) + asacu_pkg::Q_COEF[NS-1-s];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[s] <= side_in;
                p_reg[s]    <= p_next;
                q_reg[s]    <= q_next;
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_side  = side_reg[NS-1];
    assign out_p     = p_reg[NS-1];
    assign out_q     = q_reg[NS-1];

endmodule

@@ hdl/asacu_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
module asacu_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  asacu_pkg::side_t           in_side,
    input  logic [asacu_pkg::NW-1:0]   in_num,
    input  logic [asacu_pkg::AW-1:0]   in_den,
    output logic                       out_valid,
    output asacu_pkg::side_t           out_side,
    output logic [asacu_pkg::QW-1:0]   out_quo
);

    localparam int NS = asacu_pkg::QW;
    localparam int NW = asacu_pkg::NW;

    logic                     vld_reg  [NS];
    asacu_pkg::side_t         side_reg [NS];
    logic [NW-1:0]            rem_reg  [NS];
    logic [asacu_pkg::AW-1:0] den_reg  [NS];
    logic [asacu_pkg::QW-1:0] quo_reg  [NS];

    for (genvar i = 0; i < NS; i++) begin : g_stg
        localparam int B = NS - 1 - i;
        logic                     vld_in;
        asacu_pkg::side_t         side_in;
        logic [NW-1:0]            rem_in;
        logic [NW-1:0]            rem_next;
        logic [NW-1:0]            trial;
        logic [asacu_pkg::AW-1:0] den_in;
        logic [asacu_pkg::QW-1:0] quo_in;
        logic [asacu_pkg::QW-1:0] quo_next;

        if (i == 0) begin : g_first
            assign vld_in  = in_valid;
            assign side_in = in_side;
            assign rem_in  = in_num;
            assign den_in  = in_den;
            assign quo_in  = '0;
        end else begin : g_rest
            assign vld_in  = vld_reg[i-1];
            assign side_in = side_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign den_in  = den_reg[i-1];
            assign quo_in  = quo_reg[i-1];
        end

        always_comb begin
            trial = NW'(den_in) << B;
            if (rem_in >= trial) begin
                rem_next = rem_in - trial;
                quo_next = {quo_in[asacu_pkg::QW-2:0], 1'b1};
            end else begin
                rem_next = rem_in;
                quo_next = {quo_in[asacu_pkg::QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[i] <= side_in;
                rem_reg[i]  <= rem_next;
                den_reg[i]  <= den_in;
                quo_reg[i]  <= quo_next;
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_side  = side_reg[NS-1];
    assign out_quo   = quo_reg[NS-1];

endmodule

@@ hdl/arcsine_arccosine_unit.sv @@
// Top level of the arcsine/arccosine unit.
// Throughput: one item per cycle while the output is not stalled;
// the square root and divider pipelines give one bit per stage.
// A held result stalls every stage at once, so s_ready falls while m_valid waits.
// Reset is synchronous and active low and clears every valid bit; data registers keep contents.
module arcsine_arccosine_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic signed [31:0] s_x_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_angle,
    output logic               m_domain_error
);

    localparam int GW = asacu_pkg::GW;
    localparam int AW = asacu_pkg::AW;
    localparam int YW = asacu_pkg::YW;
    localparam int RW = asacu_pkg::RW;
    localparam int NW = asacu_pkg::NW;
    localparam int QW = asacu_pkg::QW;

    logic en;

    logic [31:0]      abs_x;
    asacu_pkg::side_t f1_side_next;
    asacu_pkg::side_t f1_side_reg;
    logic [GW-1:0]    f1_ax_reg;
    logic             f1_valid_reg;

    logic [59:0]      sq_prod;
    logic [GW-1:0]    ax_diff;
    logic [GW-1:0]    g_big;
    logic             big;
    asacu_pkg::side_t f2_side_next;
    asacu_pkg::side_t f2_side_reg;
    logic [GW-1:0]    f2_rad_reg;
    logic             f2_valid_reg;

    logic             sq_valid;
    asacu_pkg::side_t sq_side;
    logic [GW-1:0]    sq_root;
    asacu_pkg::side_t hn_side_in;

    logic                 hn_valid;
    asacu_pkg::side_t     hn_side;
    logic signed [AW-1:0] hn_p;
    logic signed [AW-1:0] hn_q;

    logic [AW-1:0]    pm;
    logic [AW-1:0]    qm;
    asacu_pkg::side_t d0_side_next;
    asacu_pkg::side_t d0_side_reg;
    logic [NW-1:0]    d0_num_next;
    logic [NW-1:0]    d0_num_reg;
    logic [AW-1:0]    d0_den_reg;
    logic             d0_valid_reg;

    logic             dv_valid;
    asacu_pkg::side_t dv_side;
    logic [QW-1:0]    dv_quo;

    logic [32:0]      ym;
    logic [QW-1:0]    r_mag;
    logic [64:0]      yr_prod;
    logic [64:0]      yr_round;
    asacu_pkg::side_t ml_side_reg;
    logic [32:0]      ml_yr_mag_reg;
    logic             ml_yr_neg_reg;
    logic             ml_valid_reg;

    logic signed [RW-1:0] ysx;
    logic signed [RW-1:0] yr;
    logic signed [RW-1:0] o1_res_next;
    logic signed [RW-1:0] o1_res_reg;
    asacu_pkg::side_t     o1_side_reg;
    logic                 o1_valid_reg;

    logic                 sel;
    logic signed [RW-1:0] two_a;
    logic signed [RW-1:0] two_b;
    logic signed [RW-1:0] base;
    logic signed [RW-1:0] sum;
    logic signed [RW-1:0] o2_res_next;
    logic signed [RW-1:0] o2_res_reg;
    asacu_pkg::side_t     o2_side_reg;
    logic                 o2_valid_reg;

    logic [RW-1:0]        res_mag;
    logic [RW-1:0]        res_rnd;
    logic [RW-4:0]        mr;
    logic                 res_neg;
    logic signed [31:0]   lim_half;
    logic signed [31:0]   lim_pi;
    logic signed [31:0]   m_angle_next;
    logic signed [31:0]   m_angle_reg;
    logic                 m_domain_error_reg;
    logic                 m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_comb begin
        abs_x        = s_x_value[31] ? 32'(-s_x_value) : 32'(s_x_value);
        f1_side_next = '0;
        f1_side_next.kind = s_kind;
        f1_side_next.neg  = s_x_value[31];
        f1_side_next.err  = abs_x > asacu_pkg::ONE_Q30;
        if (abs_x > asacu_pkg::ONE_Q30) begin
            f1_side_next.special    = 1'b1;
            f1_side_next.spec_angle = '0;
        end else if (abs_x == '0) begin
            f1_side_next.special    = 1'b1;
            f1_side_next.spec_angle = s_kind ? asacu_pkg::PIO2_Q29 : '0;
        end else if (abs_x == asacu_pkg::ONE_Q30) begin
            f1_side_next.special = 1'b1;
            if (!s_kind) begin
                f1_side_next.spec_angle = s_x_value[31] ? -asacu_pkg::PIO2_Q29
                                                        : asacu_pkg::PIO2_Q29;
            end else begin
                f1_side_next.spec_angle = s_x_value[31] ? asacu_pkg::PI_Q29 : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
        end else if (en) begin
            f1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_side_reg <= f1_side_next;
            f1_ax_reg   <= abs_x[GW-1:0];
        end
    end

    always_comb begin
        big          = f1_ax_reg > GW'(asacu_pkg::HALF_Q30);
        sq_prod      = 60'(f1_ax_reg[29:0]) * 60'(f1_ax_reg[29:0]);
        ax_diff      = GW'(asacu_pkg::ONE_Q30) - f1_ax_reg;
        g_big        = {ax_diff[GW-2:0], 1'b0};
        f2_side_next = f1_side_reg;
        f2_side_next.big = big;
        f2_side_next.rat = big || (f1_ax_reg >= GW'(asacu_pkg::TINY_LIMIT));
        f2_side_next.g   = big ? g_big : sq_prod[58:28];
        f2_side_next.y   = big ? '0 : $signed({1'b0, f1_ax_reg, 2'b00});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f2_valid_reg <= 1'b0;
        end else if (en) begin
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f2_side_reg <= f2_side_next;
            f2_rad_reg  <= g_big;
        end
    end

    asacu_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f2_valid_reg),
        .in_side   (f2_side_reg),
        .in_rad    (f2_rad_reg),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_root  (sq_root)
    );

    always_comb begin
        hn_side_in = sq_side;
        if (sq_side.big) begin
            hn_side_in.y = -$signed({2'b00, sq_root, 1'b0});
        end
    end

    asacu_horner u_horner (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_side   (hn_side_in),
        .out_valid (hn_valid),
        .out_side  (hn_side),
        .out_p     (hn_p),
        .out_q     (hn_q)
    );

    always_comb begin
        pm           = hn_p[AW-1] ? AW'(-hn_p) : AW'(hn_p);
        qm           = hn_q[AW-1] ? AW'(-hn_q) : AW'(hn_q);
        d0_num_next  = {pm, 32'b0} + NW'(qm >> 1);
        d0_side_next = hn_side;
        d0_side_next.rneg  = hn_p[AW-1] ^ hn_q[AW-1];
        d0_side_next.qzero = hn_q == '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d0_valid_reg <= 1'b0;
        end else if (en) begin
            d0_valid_reg <= hn_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d0_side_reg <= d0_side_next;
            d0_num_reg  <= d0_num_next;
            d0_den_reg  <= qm;
        end
    end

    asacu_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d0_valid_reg),
        .in_side   (d0_side_reg),
        .in_num    (d0_num_reg),
        .in_den    (d0_den_reg),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_quo   (dv_quo)
    );

    always_comb begin
        ym       = dv_side.y[YW-1] ? 33'(-dv_side.y) : 33'(dv_side.y);
        r_mag    = dv_side.qzero ? '0 : dv_quo;
        yr_prod  = 65'(r_mag) * 65'(ym);
        yr_round = yr_prod + (65'(1) << 31);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ml_valid_reg <= 1'b0;
        end else if (en) begin
            ml_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ml_side_reg   <= dv_side;
            ml_yr_mag_reg <= yr_round[64:32];
            ml_yr_neg_reg <= dv_side.rneg ^ dv_side.y[YW-1];
        end
    end

    always_comb begin
        ysx = $signed({{(RW-YW){ml_side_reg.y[YW-1]}}, ml_side_reg.y});
        yr  = ml_yr_neg_reg ? -$signed({4'b0, ml_yr_mag_reg}) : $signed({4'b0, ml_yr_mag_reg});
        o1_res_next = ml_side_reg.rat ? ysx + yr : ysx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o1_valid_reg <= 1'b0;
        end else if (en) begin
            o1_valid_reg <= ml_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o1_side_reg <= ml_side_reg;
            o1_res_reg  <= o1_res_next;
        end
    end

    always_comb begin
        sel   = o1_side_reg.big ? !o1_side_reg.kind : o1_side_reg.kind;
        two_a = sel ? asacu_pkg::PIO2_Q32 : '0;
        two_b = sel ? asacu_pkg::PIO2_Q32 : asacu_pkg::PI_Q32;
        base  = (o1_side_reg.kind && o1_side_reg.neg) ? two_b : two_a;
        sum   = (o1_side_reg.kind && !o1_side_reg.neg) ? base - o1_res_reg : base + o1_res_reg;
        o2_res_next = (!o1_side_reg.kind && o1_side_reg.neg) ? -sum : sum;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o2_valid_reg <= 1'b0;
        end else if (en) begin
            o2_valid_reg <= o1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o2_side_reg <= o1_side_reg;
            o2_res_reg  <= o2_res_next;
        end
    end

    always_comb begin
        res_neg  = o2_res_reg[RW-1];
        res_mag  = res_neg ? RW'(-o2_res_reg) : RW'(o2_res_reg);
        res_rnd  = res_mag + RW'(4);
        mr       = res_rnd[RW-1:3];
        lim_half = (mr > (RW-3)'(asacu_pkg::PIO2_Q29)) ? asacu_pkg::PIO2_Q29 : $signed(mr[31:0]);
        lim_pi   = (mr > (RW-3)'(asacu_pkg::PI_Q29)) ? asacu_pkg::PI_Q29 : $signed(mr[31:0]);
        if (o2_side_reg.special) begin
            m_angle_next = o2_side_reg.spec_angle;
        end else if (o2_side_reg.kind) begin
            m_angle_next = res_neg ? '0 : lim_pi;
        end else begin
            m_angle_next = res_neg ? -lim_half : lim_half;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= o2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_angle_reg        <= m_angle_next;
            m_domain_error_reg <= o2_side_reg.err;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_angle        = m_angle_reg;
    assign m_domain_error = m_domain_error_reg;

endmodule

@@ hdl/asacu_checker.sv @@
// Port-level assertions for the arcsine/arccosine unit and their binding to the top level.
module asacu_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               s_kind,
    input logic signed [31:0] s_x_value,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_angle,
    input logic               m_domain_error
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_angle) && $stable(m_domain_error))
        else $error("Result item changed while stalled.");

    a_stall_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("Input taken while the output is stalled.");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_domain_error |-> m_angle == 32'sd0)
        else $error("Domain error with a nonzero angle.");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_angle <= asacu_pkg::PI_Q29) && (m_angle >= -asacu_pkg::PIO2_Q29))
        else $error("Angle outside the output range.");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid right after reset.");

    logic unused_in;
    assign unused_in = s_valid ^ s_kind ^ s_x_value[0];

endmodule

bind arcsine_arccosine_unit asacu_checker u_asacu_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for the arcsine/arccosine unit with random handshakes.
`timescale 1ns / 1ps

module testbench;

    localparam bit OP_ASIN = 1'b0;
    localparam bit OP_ACOS = 1'b1;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        logic signed [31:0] angle;
        logic               domain_error;
    } arc_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_kind = 1'b0;
    logic signed [31:0] s_x_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_angle;
    logic               m_domain_error;

    arc_result_t pending_angles[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          stall_left = 0;

    const longint num_terms[6] = '{-64'sd459167144, 64'sd959794796, -64'sd665868627,
                                   64'sd170331058, -64'sd11689454, 64'sd0};
    const longint den_terms[6] = '{-64'sd2755002865, 64'sd6998520066, -64'sd6406598597,
                                   64'sd2532566195, -64'sd399698031, 64'sd16777216};

    arcsine_arccosine_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind), .s_x_value(s_x_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_angle(m_angle), .m_domain_error(m_domain_error)
    );

    always #5 aclk = ~aclk;

    function automatic longint scale_q32(longint a, longint unsigned b);
        longint unsigned mag;
        longint unsigned prod;
        mag = (a < 0) ? longint'(0) - a : a;
        prod = mag * b;
        prod = (prod + (64'd1 << 31)) >> 32;
        return (a < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    function automatic longint poly_eval(input longint c[6], int top, longint unsigned g);
        longint acc;
        acc = c[top];
        for (int k = top - 1; k >= 0; k--) acc = scale_q32(acc, g) + c[k];
        return acc;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= r + bitv) begin
                v -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic longint core_angle(bit kind, bit neg, logic [31:0] ax);
        longint unsigned g;
        longint unsigned pm;
        longint unsigned qm;
        longint unsigned rm;
        longint unsigned ym;
        longint y;
        longint res;
        longint pv;
        longint qv;
        longint r;
        longint yr;
        longint off_a;
        longint off_b;
        longint unsigned m;
        longint outv;
        bit rat;
        bit sel;
        g = 0;
        if (ax > asacu_pkg::HALF_Q30) begin
            sel = !kind;
            g = longint'(asacu_pkg::ONE_Q30 - ax) << 1;
            y = -longint'(int_sqrt(g << 32) << 1);
            rat = 1'b1;
        end else begin
            sel = kind;
            y = longint'(ax) << 2;
            rat = ax >= asacu_pkg::TINY_LIMIT;
            if (rat) g = (longint'(ax) * longint'(ax)) >> 28;
        end
        res = y;
        if (rat) begin
            pv = scale_q32(poly_eval(num_terms, 4, g), g);
            qv = poly_eval(den_terms, 5, g);
            pm = (pv < 0) ? longint'(0) - pv : pv;
            qm = (qv < 0) ? longint'(0) - qv : qv;
            r = 0;
            if (qm != 0) begin
                rm = ((pm << 32) + (qm >> 1)) / qm;
                r = ((pv < 0) != (qv < 0)) ? -longint'(rm) : longint'(rm);
            end
            ym = (y < 0) ? longint'(0) - y : y;
            yr = scale_q32(r, ym);
            if (y < 0) yr = -yr;
            res = y + yr;
        end
        off_a = sel ? longint'(asacu_pkg::PIO2_Q32) : 0;
        off_b = sel ? longint'(asacu_pkg::PIO2_Q32) : longint'(asacu_pkg::PI_Q32);
        if (kind == OP_ASIN) begin
            res += off_a;
            if (neg) res = -res;
        end else if (neg) begin
            res += off_b;
        end else begin
            res = off_a - res;
        end
        m = (res < 0) ? longint'(0) - res : res;
        m = (m + 4) >> 3;
        outv = (res < 0) ? -longint'(m) : longint'(m);
        if (kind == OP_ASIN) begin
            if (outv > asacu_pkg::PIO2_Q29) outv = asacu_pkg::PIO2_Q29;
            if (outv < -longint'(asacu_pkg::PIO2_Q29)) outv = -longint'(asacu_pkg::PIO2_Q29);
        end else begin
            if (outv > asacu_pkg::PI_Q29) outv = asacu_pkg::PI_Q29;
            if (outv < 0) outv = 0;
        end
        return outv;
    endfunction

    function automatic arc_result_t predict_angle(bit kind, logic [31:0] raw);
        arc_result_t res;
        logic [31:0] ax;
        bit neg;
        neg = raw[31];
        ax = neg ? -raw : raw;
        res.domain_error = 1'b0;
        res.angle = '0;
        if (ax > asacu_pkg::ONE_Q30) begin
            res.domain_error = 1'b1;
        end else if (ax == 0) begin
            res.angle = (kind == OP_ACOS) ? asacu_pkg::PIO2_Q29 : 32'sd0;
        end else if (ax == asacu_pkg::ONE_Q30) begin
            if (kind == OP_ASIN) res.angle = neg ? -asacu_pkg::PIO2_Q29 : asacu_pkg::PIO2_Q29;
            else res.angle = neg ? asacu_pkg::PI_Q29 : 32'sd0;
        end else begin
            res.angle = 32'(core_angle(kind, neg, ax));
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    task automatic send_item(bit kind, logic [31:0] x, bit with_gaps = 1'b1);
        int gap;
        gap = with_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_x_value <= x;
        do @(posedge aclk); while (!(s_valid && s_ready));
        pending_angles.push_back(predict_angle(kind, x));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_angles.size() == 0) begin
                report_mismatch("unexpected item", m_angle, 0);
            end else begin
                arc_result_t want;
                want = pending_angles.pop_front();
                if (m_angle !== want.angle) report_mismatch("angle", m_angle, want.angle);
                if (m_domain_error !== want.domain_error)
                    report_mismatch("domain_error", m_domain_error, want.domain_error);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (cycle_count % 2000 < 400) begin
            m_ready <= 1'b1;
        end else begin
            int p;
            p = $urandom_range(0, 99);
            if (p < 20) stall_left <= $urandom_range(0, 2);
            else if (p < 22) stall_left <= $urandom_range(15, 50);
            m_ready <= (p >= 22);
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic test_directed();
        logic [31:0] edges[] = '{32'h0000_0000, 32'h4000_0000, 32'hC000_0000,
            32'h4000_0001, 32'hBFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h0000_000B, 32'h0000_000C, 32'hFFFF_FFF5, 32'h2000_0000,
            32'h2000_0001, 32'hDFFF_FFFF, 32'h3FFF_FFFF, 32'hC000_0001};
        foreach (edges[i]) begin
            send_item(OP_ASIN, edges[i]);
            if (i < 10) send_item(OP_ACOS, edges[i]);
        end
    endtask

    task automatic test_random(int count);
        logic [31:0] x;
        int p;
        for (int i = 0; i < count; i++) begin
            p = $urandom_range(0, 99);
            if (p < 40) x = 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
            else if (p < 55) x = $urandom() >>> $urandom_range(2, 31);
            else if (p < 65) x = $urandom_range(0, 30);
            else if (p < 75) x = (($urandom_range(0, 1) ? asacu_pkg::ONE_Q30
                                                        : asacu_pkg::HALF_Q30)
                                  + $urandom_range(0, 8) - 4);
            else x = $urandom();
            if (p >= 55 && p < 75 && $urandom_range(0, 1)) x = -x;
            send_item(bit'($urandom_range(0, 1)), x);
        end
    endtask

    task automatic test_drain_pause();
        s_valid <= 1'b0;
        while (pending_angles.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        for (int i = 0; i < 40; i++) send_item(bit'(i & 1), $urandom(), 1'b0);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(350);
        test_drain_pause();
        test_random(360);
        s_valid <= 1'b0;
        while (pending_angles.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
